FILE: sv/isl_pkg.sv
// Shared types and codes for the indexed sequence list.
`default_nettype none

package isl_pkg;

    typedef enum logic [3:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_READ_BACK  = 4'd4,
        OP_READ_FRONT = 4'd5,
        OP_READ_AT    = 4'd6,
        OP_INSERT_AT  = 4'd7,
        OP_REMOVE_AT  = 4'd8,
        OP_CLEAR      = 4'd9,
        OP_SIZE       = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_GRAB,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [7:0]         index;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] value;
        status_t            status;
        logic [4:0]         count;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/isl_if.sv
// Valid/ready channel interfaces for operations and results.
`default_nettype none

interface isl_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic [7:0]         index;
    logic signed [31:0] value_in;

    modport source (output valid, output opcode, output index, output value_in, input ready);
    modport sink (input valid, input opcode, input index, input value_in, output ready);
endinterface

interface isl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [4:0]         count_out;

    modport source (output valid, output value_out, output status, output count_out,
                    input ready);
    modport sink (input valid, input value_out, input status, input count_out,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/isl_mem.sv
// Element store: one write port, one read port with registered read data.
`default_nettype none

module isl_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic signed [31:0]         wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic signed [31:0]              rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/isl_ctrl.sv
// Sequencer: decodes an operation and moves entries one step at a time.
`default_nettype none

module isl_ctrl #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire isl_pkg::cmd_t                 cmd,
    input  wire logic                          slot_free,
    output logic                               res_valid,
    output isl_pkg::result_t                   res,
    output logic                               mem_we,
    output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
    output logic signed [31:0]                 mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(CAPACITY)-1:0]        mem_raddr,
    input  wire logic signed [31:0]            mem_rdata
);

    import isl_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      lim_reg, lim_next;
    logic signed [31:0] din_reg, din_next;
    logic signed [31:0] rval_reg, rval_next;
    status_t            stat_reg, stat_next;
    logic               rm_reg, rm_next;
    logic               dir_reg, dir_next;

    logic               accept;
    logic               empty;
    logic               full;
    logic [CW-1:0]      cnt_m1;
    logic [AW-1:0]      cnt_a;
    logic [AW-1:0]      last_a;
    logic [AW-1:0]      idx_a;
    logic [CMPW-1:0]    cnt_c;
    logic [CMPW-1:0]    idx_c;
    logic [AW-1:0]      src;
    logic [CW+4:0]      cnt_wide;

    assign accept = in_valid && in_ready;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(CAPACITY));
    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_a  = count_reg[AW-1:0];
    assign last_a = cnt_m1[AW-1:0];
    assign idx_a  = AW'(cmd.index);
    assign cnt_c  = CMPW'(count_reg);
    assign idx_c  = CMPW'(cmd.index);

    // Shared step unit: source slot next to the destination pointer
    assign src = dir_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));

    // Count field is the count masked to five bits
    assign cnt_wide = {5'b0, count_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        lim_reg  <= lim_next;
        din_reg  <= din_next;
        rval_reg <= rval_next;
        stat_reg <= stat_next;
        rm_reg   <= rm_next;
        dir_reg  <= dir_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        lim_next   = lim_reg;
        din_next   = din_reg;
        rval_next  = rval_reg;
        stat_next  = stat_reg;
        rm_next    = rm_reg;
        dir_next   = dir_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg;
        mem_wdata  = din_reg;
        mem_re     = 1'b0;
        mem_raddr  = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    din_next   = cmd.value;
                    rval_next  = '0;
                    stat_next  = ST_OK;
                    rm_next    = 1'b0;
                    dir_next   = 1'b0;
                    state_next = S_DONE;
                    unique case (opcode_t'(cmd.opcode)) inside
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next = cnt_a;
                                lim_next = (opcode_t'(cmd.opcode) == OP_PUSH_BACK) ? cnt_a : '0;
                                state_next = ((opcode_t'(cmd.opcode) == OP_PUSH_BACK) ||
                                              empty) ? S_PUT : S_SH_RD;
                            end
                        end
                        OP_INSERT_AT:
                        begin
                            if (idx_c > cnt_c)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = cnt_a;
                                lim_next   = idx_a;
                                state_next = (idx_a == cnt_a) ? S_PUT : S_SH_RD;
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT, OP_READ_BACK, OP_READ_FRONT:
                        begin
                            if (empty)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next = ((opcode_t'(cmd.opcode) == OP_POP_BACK) ||
                                            (opcode_t'(cmd.opcode) == OP_READ_BACK)) ?
                                           last_a : '0;
                                lim_next   = last_a;
                                rm_next    = (opcode_t'(cmd.opcode) == OP_POP_BACK) ||
                                             (opcode_t'(cmd.opcode) == OP_POP_FRONT);
                                dir_next   = 1'b1;
                                state_next = S_GET;
                            end
                        end
                        OP_READ_AT, OP_REMOVE_AT:
                        begin
                            if (idx_c >= cnt_c)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = idx_a;
                                lim_next   = last_a;
                                rm_next    = (opcode_t'(cmd.opcode) == OP_REMOVE_AT);
                                dir_next   = 1'b1;
                                state_next = S_GET;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end

            // Read the addressed entry
            S_GET:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg;
                state_next = S_GRAB;
            end

            // Capture the value, then close the gap if removing
            S_GRAB:
            begin
                rval_next = mem_rdata;
                if (!rm_reg)
                begin
                    state_next = S_DONE;
                end
                else if (ptr_reg == lim_reg)
                begin
                    count_next = cnt_m1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end

            // Fetch the neighbor that moves into the pointer slot
            S_SH_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = src;
                state_next = S_SH_WR;
            end

            // Drop the neighbor into place and advance
            S_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = src;
                if (src == lim_reg)
                begin
                    if (dir_reg)
                    begin
                        count_next = cnt_m1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end

            // Write the new value into the opened slot
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = din_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // Hand the result over once the output slot is free
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.value  = rval_reg;
    assign res.status = stat_reg;
    assign res.count  = cnt_wide[4:0];

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode_t'(cmd.opcode) == OP_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty the list");

    a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == ST_FULL) |-> full)
        else $error("full status while below capacity");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status != ST_OK) |-> res.value == '0)
        else $error("nonzero value on failed operation");

endmodule

`default_nettype wire

FILE: sv/indexed_sequence_list.sv
// Indexed sequence list: a bounded ordered list of signed 32-bit values.
//
// Operations arrive on in_ch (opcode, index, value_in) and each gives
// exactly one result on out_ch (value_out, status, count_out). Both are
// valid/ready channels; a transfer happens when valid and ready are high.
// One operation is worked on at a time; in_ch.ready is high only while
// the sequencer is idle. Each entry moves one slot by a read, then a
// write of the element store, so the cost is set by the shift loop.
// Size, clear, errors and unused codes go straight to the result;
// reads fetch one entry; a pop or remove at position p shifts the
// entries after p toward the front; a push or insert at position p
// shifts the entries from p on toward the back (none for push back).
// The result shows on out_ch in the same cycle that in_ch.ready returns.
// The result sits in an output register; the next operation is accepted
// while it waits, and only its hand-over stalls until out_ch is taken.
// Reset empties the list and drops any pending result; the store itself
// is not cleared and needs no sweep.
`default_nettype none

module indexed_sequence_list #(
    parameter int CAPACITY = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    isl_in_if.sink        in_ch,
    isl_out_if.source     out_ch
);

    import isl_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    cmd_t               cmd;
    result_t            res;
    logic               res_valid;
    logic               slot_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;
    logic               out_valid_reg;
    result_t            out_res_reg;

    assign cmd.opcode = in_ch.opcode;
    assign cmd.index  = in_ch.index;
    assign cmd.value  = in_ch.value_in;

    isl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .cmd       (cmd),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    isl_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ch.ready;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value_out = out_res_reg.value;
    assign out_ch.status    = out_res_reg.status;
    assign out_ch.count_out = out_res_reg.count;

endmodule

`default_nettype wire

FILE: dv/indexed_sequence_list_test.sv
// Self-checking testbench for the indexed sequence list.
`default_nettype none

module indexed_sequence_list_test;

    import isl_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_OPS   = 1520;
    localparam int HOLD_EVERY   = 250;
    localparam int CALM_EVERY   = 150;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [3:0]         OP_UNUSED_FIRST = 4'd11;
    localparam logic [3:0]         OP_UNUSED_LAST  = 4'd15;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [3:0]         opcode;
        logic [7:0]         index;
        logic signed [31:0] value;
        int                 reps;
        bit                 typed;
        result_t            res;
    } plan_row_t;

    logic clk;
    logic rst_n;

    isl_in_if  in_ch();
    isl_out_if out_ch();

    indexed_sequence_list #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the list contents
    logic signed [31:0] list_mem [CAPACITY+1];
    int                 list_len = 0;

    result_t   expected_q [$];
    plan_row_t plan_q [$];
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    int        stall_left = 0;
    bit        calm = 1'b0;
    bit        grow = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // Shift entries toward the back and store the new value
    function automatic void open_slot(int pos, logic signed [31:0] val);
        for (int i = list_len; i > pos; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[pos] = val;
        list_len++;
    endfunction

    // Take out one entry and shift the rest toward the front
    function automatic logic signed [31:0] close_slot(int pos);
        logic signed [31:0] v;
        v = list_mem[pos];
        for (int i = pos; i < list_len - 1; i++)
            list_mem[i] = list_mem[i+1];
        list_len--;
        return v;
    endfunction

    // Apply one operation to the shadow list and return its result
    function automatic result_t apply_list_op(logic [3:0] op, logic [7:0] idx,
                                              logic signed [31:0] val);
        result_t r;
        r.value  = '0;
        r.status = ST_OK;
        case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                    open_slot((op == OP_PUSH_BACK) ? list_len : 0, val);
            OP_POP_BACK, OP_POP_FRONT:
                if (list_len == 0)
                    r.status = ST_RANGE;
                else
                    r.value = close_slot((op == OP_POP_BACK) ? list_len - 1 : 0);
            OP_READ_BACK, OP_READ_FRONT:
                if (list_len == 0)
                    r.status = ST_RANGE;
                else
                    r.value = list_mem[(op == OP_READ_BACK) ? list_len - 1 : 0];
            OP_READ_AT:
                if (int'(idx) >= list_len)
                    r.status = ST_RANGE;
                else
                    r.value = list_mem[idx];
            OP_INSERT_AT:
                if (int'(idx) > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                    open_slot(int'(idx), val);
            OP_REMOVE_AT:
                if (int'(idx) >= list_len)
                    r.status = ST_RANGE;
                else
                    r.value = close_slot(int'(idx));
            OP_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        r.count = 5'(list_len);
        return r;
    endfunction

    task automatic add_row(logic [3:0] op, int idx, logic signed [31:0] val, int reps,
                           bit typed, status_t st, int cnt);
        plan_row_t row;
        row.opcode     = op;
        row.index      = 8'(idx);
        row.value      = val;
        row.reps       = reps;
        row.typed      = typed;
        row.res.value  = '0;
        row.res.status = st;
        row.res.count  = 5'(cnt);
        plan_q.insert(plan_q.size(), row);
    endtask

    // Drive one operation, wait for its transfer, then log what it should return
    task automatic send_op(logic [3:0] op, logic [7:0] idx, logic signed [31:0] val,
                           bit typed, result_t typed_res);
        result_t exp_res;
        int      gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= op;
        in_ch.index    <= idx;
        in_ch.value_in <= val;
        do
            @(posedge clk);
        while (!in_ch.ready);
        exp_res = apply_list_op(op, idx, val);
        if (typed)
            exp_res = typed_res;
        expected_q.insert(expected_q.size(), exp_res);
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic hold_until_empty();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    // Check results and randomize back-pressure on the result side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no operation outstanding");
                    err_cnt++;
                end
                else
                begin
                    result_t exp_res;
                    exp_res = expected_q[0];
                    expected_q.delete(0);
                    if (out_ch.value_out !== exp_res.value)
                    begin
                        $error("value_out: expected %0d, got %0d", exp_res.value,
                               out_ch.value_out);
                        err_cnt++;
                    end
                    if (out_ch.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status,
                               out_ch.status);
                        err_cnt++;
                    end
                    if (out_ch.count_out !== exp_res.count)
                    begin
                        $error("count_out: expected %0d, got %0d", exp_res.count,
                               out_ch.count_out);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [3:0]         op;
        logic [7:0]         idx;
        logic signed [31:0] val;
        int                 r;
        result_t            no_res;

        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.opcode   = OP_SIZE;
        in_ch.index    = '0;
        in_ch.value_in = '0;
        out_ch.ready   = 1'b0;
        no_res.value   = '0;
        no_res.status  = ST_OK;
        no_res.count   = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, fill to capacity, full and range errors
        add_row(OP_SIZE,        0,            '0,            1, 1, ST_OK,    0);
        add_row(OP_POP_BACK,    0,            '0,            1, 1, ST_RANGE, 0);
        add_row(OP_READ_FRONT,  0,            '0,            1, 1, ST_RANGE, 0);
        add_row(OP_READ_AT,     255,          '0,            1, 1, ST_RANGE, 0);
        add_row(OP_INSERT_AT,   1,            32'sh1234_5678, 1, 1, ST_RANGE, 0);
        add_row(OP_PUSH_BACK,   0,            VAL_MAX,       1, 1, ST_OK,    1);
        add_row(OP_PUSH_FRONT,  0,            VAL_MIN,       1, 1, ST_OK,    2);
        add_row(OP_INSERT_AT,   1,            -32'sd1,       1, 0, ST_OK,    0);
        add_row(OP_READ_AT,     2,            '0,            1, 0, ST_OK,    0);
        add_row(OP_REMOVE_AT,   1,            '0,            1, 0, ST_OK,    0);
        add_row(OP_PUSH_BACK,   0,            32'sh5a5a_0000, CAPACITY - 2, 0, ST_OK, 0);
        add_row(OP_PUSH_FRONT,  0,            32'sh0f0f_0f0f, 1, 1, ST_FULL,  CAPACITY);
        add_row(OP_INSERT_AT,   CAPACITY + 1, '0,            1, 1, ST_RANGE, CAPACITY);
        add_row(OP_INSERT_AT,   CAPACITY,     '0,            1, 1, ST_FULL,  CAPACITY);
        add_row(OP_READ_AT,     CAPACITY,     '0,            1, 1, ST_RANGE, CAPACITY);
        add_row(OP_POP_FRONT,   0,            '0,            1, 0, ST_OK,    0);
        add_row(OP_POP_BACK,    0,            '0,            1, 0, ST_OK,    0);
        add_row(OP_UNUSED_LAST, 255,          -32'sd1,       1, 1, ST_OK,    CAPACITY - 2);
        add_row(OP_CLEAR,       170,          '0,            1, 1, ST_OK,    0);
        add_row(OP_REMOVE_AT,   0,            '0,            1, 1, ST_RANGE, 0);

        foreach (plan_q[i])
        begin
            for (int k = 0; k < plan_q[i].reps; k++)
                send_op(plan_q[i].opcode, plan_q[i].index, plan_q[i].value + k,
                        plan_q[i].typed, plan_q[i].res);
        end

        // Random: alternate growing and shrinking runs so the list swings empty to full
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % CALM_EVERY == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (n % HOLD_EVERY == HOLD_EVERY - 1)
                hold_until_empty();

            if (list_len >= CAPACITY && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            else if (list_len == 0 && $urandom_range(0, 1) == 0)
                grow = 1'b1;

            r = $urandom_range(0, 99);
            if (r < 3)
                op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            else if (r < 5)
                op = OP_CLEAR;
            else if (r < 8)
                op = OP_SIZE;
            else if (r < (grow ? 60 : 30))
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_PUSH_BACK;
                    1:       op = OP_PUSH_FRONT;
                    default: op = OP_INSERT_AT;
                endcase
            end
            else if (r < (grow ? 72 : 70))
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_POP_BACK;
                    1:       op = OP_POP_FRONT;
                    default: op = OP_REMOVE_AT;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_READ_BACK;
                    1:       op = OP_READ_FRONT;
                    default: op = OP_READ_AT;
                endcase
            end

            // Positions mostly in range, some at the boundary, some anywhere
            r = $urandom_range(0, 9);
            if (r < 7)
                idx = 8'($urandom_range(0, list_len));
            else if (r < 8)
                idx = 8'(list_len);
            else
                idx = 8'($urandom_range(0, 255));

            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       val = VAL_MIN;
                    1:       val = VAL_MAX;
                    2:       val = '0;
                    default: val = -32'sd1;
                endcase
            end
            else
                val = $urandom;

            send_op(op, idx, val, 1'b0, no_res);
        end

        // Drain outstanding results, then watch for strays
        in_ch.valid <= 1'b0;
        calm = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_cnt == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
